FILE: hw/rtl/refcounted_page_frame_allocator_core_defines.svh
// Assertion macros used by the allocator core.
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RPFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rpfa_pkg.sv
package rpfa_pkg;

  // Geometry
  localparam int unsigned NUM_PAGES   = 32768;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned BASE_PAGE   = 524288;
  localparam int unsigned COUNT_WIDTH = 16;

  // Port widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FREE_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Derived widths
  localparam int unsigned IDX_W      = $clog2(NUM_PAGES);
  localparam int unsigned DEPTH_W    = $clog2(NUM_PAGES + 1);
  localparam int unsigned PN_W       = ADDR_W - PAGE_SHIFT;
  // wide enough for BASE_PAGE + NUM_PAGES and for a rounded-up page number
  localparam int unsigned FRAME_PN_W = 24;

  localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NUM_PAGES - 1);
  localparam logic [DEPTH_W-1:0]     DEPTH_MAX = DEPTH_W'(NUM_PAGES);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
  localparam logic [FRAME_PN_W-1:0]  PN_LO     = FRAME_PN_W'(BASE_PAGE);
  localparam logic [FRAME_PN_W-1:0]  PN_HI     = FRAME_PN_W'(BASE_PAGE + NUM_PAGES);

  // Config reset values
  localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] PHYS_TOP_RST   = 32'h8800_0000;

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC      = 3'd0,
    FN_FREE       = 3'd1,
    FN_ADDREF     = 3'd2,
    FN_COPY_DEREF = 3'd3,
    FN_INIT       = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_OOM      = 3'd1,
    STAT_BAD_ADDR = 3'd2,
    STAT_NO_REF   = 3'd3,
    STAT_SAT      = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_END = 1'b0,
    CFG_PHYS_TOP   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_FIXUP,
    BK_INIT
  } bk_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] kernel_end;
    logic [ADDR_W-1:0] phys_top;
  } rpfa_cfg_t;

  typedef struct packed {
    func_e             func;
    logic [ADDR_W-1:0] page_addr;
    logic              addr_ok;
    logic [IDX_W-1:0]  idx;
  } rpfa_item_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] addr;
    logic              copy_needed;
    logic              page_freed;
    logic [FREE_W-1:0] free_pages;
  } rpfa_result_t;

  typedef struct packed {
    logic clearing;
  } rpfa_stat_t;

  // Byte address of a managed frame, truncated to the bus width.
  function automatic logic [ADDR_W-1:0] frame_addr(input logic [IDX_W-1:0] idx);
    logic [FRAME_PN_W-1:0]            pn;
    logic [FRAME_PN_W+PAGE_SHIFT-1:0] full;
    pn   = PN_LO + FRAME_PN_W'(idx);
    full = {pn, {PAGE_SHIFT{1'b0}}};
    return full[ADDR_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/rpfa_ram.sv
module rpfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/rpfa_front.sv
module rpfa_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  rpfa_pkg::rpfa_cfg_t          cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rpfa_pkg::FUNC_W-1:0]  func_i,
  input  logic [rpfa_pkg::ADDR_W-1:0]  page_addr_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output rpfa_pkg::rpfa_item_t         item_o
);

  import rpfa_pkg::*;

  logic                  valid_d, valid_q;
  rpfa_item_t            item_d, item_q;
  logic                  accept;
  logic [FRAME_PN_W-1:0] pn, offs;
  logic                  aligned, above_kernel, below_top, in_window;

  // Address classification
  assign pn           = FRAME_PN_W'(page_addr_i[ADDR_W-1:PAGE_SHIFT]);
  assign offs         = pn - PN_LO;
  assign aligned      = (page_addr_i[PAGE_SHIFT-1:0] == '0);
  assign above_kernel = (page_addr_i >= cfg_i.kernel_end);
  assign below_top    = (page_addr_i < cfg_i.phys_top);
  assign in_window    = (pn >= PN_LO) && (pn < PN_HI);

  assign in_ready_o = en_i && (!valid_q || item_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d           = 1'b1;
      item_d.func       = func_e'(func_i);
      item_d.page_addr  = page_addr_i;
      item_d.addr_ok    = aligned && above_kernel && below_top && in_window;
      item_d.idx        = offs[IDX_W-1:0];
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: hw/rtl/rpfa_queue.sv
module rpfa_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  rpfa_pkg::rpfa_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output rpfa_pkg::rpfa_item_t pop_item_o
);

  import rpfa_pkg::*;

  rpfa_item_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_d, cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: hw/rtl/rpfa_back.sv
module rpfa_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rpfa_pkg::rpfa_cfg_t    cfg_i,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  rpfa_pkg::rpfa_item_t   item_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output rpfa_pkg::rpfa_result_t res_o,
  output rpfa_pkg::rpfa_stat_t   stat_o
);

  import rpfa_pkg::*;

  bk_state_e             state_d, state_q;
  rpfa_item_t            cur_d, cur_q;
  logic [DEPTH_W-1:0]    depth_d, depth_q, depth_m1;
  logic [IDX_W-1:0]      sweep_d, sweep_q;
  logic [IDX_W-1:0]      nidx_d, nidx_q;
  logic [COUNT_WIDTH-1:0] cnt_hold_d, cnt_hold_q;
  logic [FRAME_PN_W-1:0] init_lo_d, init_lo_q, init_hi_d, init_hi_q;
  logic                  res_valid_d, res_valid_q;
  rpfa_result_t          res_d, res_q, rb;
  logic                  res_free, start, go_fixup;

  logic [ADDR_W:0]        lo_sum;
  logic [FRAME_PN_W-1:0]  sweep_pn;
  logic                   sweep_hit;

  // count memory ports
  logic                   cnt_we, cnt_re;
  logic [IDX_W-1:0]       cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  // stack memory ports
  logic                   stk_we, stk_re;
  logic [IDX_W-1:0]       stk_waddr, stk_raddr, stk_rdata, stk_wdata_w;

  rpfa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_PAGES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (item_i.idx),
    .rdata_o (cnt_rdata)
  );

  rpfa_ram #(.WIDTH(IDX_W), .DEPTH(NUM_PAGES)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata_w),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign res_free  = !res_valid_q || res_ready_i;
  assign start     = (state_q == BK_IDLE) && item_valid_i && res_free;
  assign depth_m1  = depth_q - DEPTH_W'(1);
  assign stk_raddr = depth_m1[IDX_W-1:0];
  assign lo_sum    = {1'b0, cfg_i.kernel_end} + (ADDR_W + 1)'({PAGE_SHIFT{1'b1}});
  assign sweep_pn  = PN_LO + FRAME_PN_W'(sweep_q);
  assign sweep_hit = (sweep_pn >= init_lo_q) && (sweep_pn < init_hi_q);

  // copy_deref that needs a fresh page does a second count write in BK_FIXUP
  assign go_fixup = (cur_q.func == FN_COPY_DEREF) && cur_q.addr_ok &&
                    (cnt_rdata != '0) && (cnt_rdata != COUNT_WIDTH'(1)) &&
                    (depth_q != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: begin
        if (sweep_q == LAST_IDX) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (start) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (cur_q.func == FN_INIT) begin
          state_d = BK_INIT;
        end else if (go_fixup) begin
          state_d = BK_FIXUP;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_FIXUP: begin
        state_d = BK_IDLE;
      end
      BK_INIT: begin
        if (sweep_q == LAST_IDX) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cur_d       = cur_q;
    depth_d     = depth_q;
    sweep_d     = sweep_q;
    nidx_d      = nidx_q;
    cnt_hold_d  = cnt_hold_q;
    init_lo_d   = init_lo_q;
    init_hi_d   = init_hi_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    cnt_we      = 1'b0;
    cnt_re      = 1'b0;
    cnt_waddr   = cur_q.idx;
    cnt_wdata   = '0;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_waddr   = depth_q[IDX_W-1:0];
    stk_wdata_w = cur_q.idx;
    item_ready_o = 1'b0;
    rb          = '{status: STAT_OK, addr: '0, copy_needed: 1'b0,
                    page_freed: 1'b0, free_pages: '0};

    case (state_q)
      BK_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = sweep_q;
        sweep_d   = (sweep_q == LAST_IDX) ? '0 : sweep_q + IDX_W'(1);
      end
      BK_IDLE: begin
        item_ready_o = res_free;
        if (start) begin
          cur_d  = item_i;
          cnt_re = 1'b1;
          stk_re = (depth_q != '0);
        end
      end
      BK_EXEC: begin
        case (cur_q.func)
          FN_ALLOC: begin
            if (depth_q == '0) begin
              rb.status = STAT_OOM;
            end else begin
              depth_d   = depth_m1;
              cnt_we    = 1'b1;
              cnt_waddr = stk_rdata;
              cnt_wdata = COUNT_WIDTH'(1);
              rb.addr   = frame_addr(stk_rdata);
            end
          end
          FN_FREE: begin
            if (!cur_q.addr_ok) begin
              rb.status = STAT_BAD_ADDR;
            end else if (cnt_rdata == '0) begin
              rb.status = STAT_NO_REF;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rdata - COUNT_WIDTH'(1);
              rb.addr   = cur_q.page_addr;
              if (cnt_rdata == COUNT_WIDTH'(1)) begin
                rb.page_freed = 1'b1;
                // a full stack drops the push
                if (depth_q < DEPTH_MAX) begin
                  stk_we  = 1'b1;
                  depth_d = depth_q + DEPTH_W'(1);
                end
              end
            end
          end
          FN_ADDREF: begin
            if (!cur_q.addr_ok) begin
              rb.status = STAT_BAD_ADDR;
            end else if (cnt_rdata == CNT_MAX) begin
              rb.status = STAT_SAT;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rdata + COUNT_WIDTH'(1);
              rb.addr   = cur_q.page_addr;
            end
          end
          FN_COPY_DEREF: begin
            if (!cur_q.addr_ok) begin
              rb.status = STAT_BAD_ADDR;
            end else if (cnt_rdata == '0) begin
              rb.status = STAT_NO_REF;
            end else if (cnt_rdata == COUNT_WIDTH'(1)) begin
              rb.addr = cur_q.page_addr;
            end else if (depth_q == '0) begin
              rb.status = STAT_OOM;
            end else begin
              depth_d    = depth_m1;
              cnt_we     = 1'b1;
              cnt_waddr  = stk_rdata;
              cnt_wdata  = COUNT_WIDTH'(1);
              nidx_d     = stk_rdata;
              cnt_hold_d = cnt_rdata;
            end
          end
          FN_INIT: begin
            depth_d   = '0;
            sweep_d   = '0;
            init_lo_d = FRAME_PN_W'(lo_sum[ADDR_W:PAGE_SHIFT]);
            init_hi_d = FRAME_PN_W'(cfg_i.phys_top[ADDR_W-1:PAGE_SHIFT]);
          end
          default: begin
          end
        endcase
        if ((cur_q.func != FN_INIT) && !go_fixup) begin
          rb.free_pages = FREE_W'(depth_d);
          res_d         = rb;
          res_valid_d   = 1'b1;
        end
      end
      BK_FIXUP: begin
        // new page already holds 1; old count drops, or the new page if it is the same frame
        cnt_we    = 1'b1;
        cnt_waddr = cur_q.idx;
        cnt_wdata = (nidx_q == cur_q.idx) ? '0 : cnt_hold_q - COUNT_WIDTH'(1);
        rb.addr        = frame_addr(nidx_q);
        rb.copy_needed = 1'b1;
        rb.free_pages  = FREE_W'(depth_q);
        res_d          = rb;
        res_valid_d    = 1'b1;
      end
      BK_INIT: begin
        cnt_we      = 1'b1;
        cnt_waddr   = sweep_q;
        stk_wdata_w = sweep_q;
        if (sweep_hit && (depth_q < DEPTH_MAX)) begin
          stk_we  = 1'b1;
          depth_d = depth_q + DEPTH_W'(1);
        end
        sweep_d = (sweep_q == LAST_IDX) ? '0 : sweep_q + IDX_W'(1);
        if (sweep_q == LAST_IDX) begin
          rb.free_pages = FREE_W'(depth_d);
          res_d         = rb;
          res_valid_d   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      depth_q     <= '0;
      sweep_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      sweep_q     <= sweep_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    nidx_q     <= nidx_d;
    cnt_hold_q <= cnt_hold_d;
    init_lo_q  <= init_lo_d;
    init_hi_q  <= init_hi_d;
    res_q      <= res_d;
  end

  assign res_valid_o     = res_valid_q;
  assign res_o           = res_q;
  assign stat_o.clearing = (state_q == BK_CLEAR);

endmodule

FILE: hw/rtl/refcounted_page_frame_allocator_core.sv
// Channel   Handshake                 Beat payload
// in        in_valid_i / in_ready_o   func_i, page_addr_i
// out       out_valid_o / out_ready_i status_o, result_addr_o, copy_needed_o,
//                                     page_freed_o, free_pages_o
// cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Sequence: alloc, free, addref and copy_deref each read the count/stack
//   memories in the back end, then write; copy_deref that hands out a new
//   page writes again in FIXUP (two writes to the single count-memory port).
//   Init sweeps all NUM_PAGES frames; the back end holds one item at a time.
// Reset: counts are cleared by a sweep of all NUM_PAGES frames (32768); no beat
//   is taken on the in channel until it ends. Config writes are taken always.
// Stalls: front register and a 2-entry queue keep taking beats while a result
//   waits in the output register.
`include "refcounted_page_frame_allocator_core_defines.svh"

module refcounted_page_frame_allocator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rpfa_pkg::FUNC_W-1:0]    func_i,
  input  logic [rpfa_pkg::ADDR_W-1:0]    page_addr_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rpfa_pkg::STATUS_W-1:0]  status_o,
  output logic [rpfa_pkg::ADDR_W-1:0]    result_addr_o,
  output logic                           copy_needed_o,
  output logic                           page_freed_o,
  output logic [rpfa_pkg::FREE_W-1:0]    free_pages_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rpfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rpfa_pkg::ADDR_W-1:0]    cfg_data_i
);

  import rpfa_pkg::*;

  // Config registers: kernel end and top of managed memory
  logic [ADDR_W-1:0] kernel_end_d, kernel_end_q;
  logic [ADDR_W-1:0] phys_top_d, phys_top_q;
  rpfa_cfg_t         cfg;

  // Front -> queue -> back
  logic         fr_valid, fr_ready;
  rpfa_item_t   fr_item;
  logic         q_valid, q_ready;
  rpfa_item_t   q_item;
  rpfa_result_t res;
  rpfa_stat_t   stat;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    kernel_end_d = kernel_end_q;
    phys_top_d   = phys_top_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_KERNEL_END: kernel_end_d = cfg_data_i;
        CFG_PHYS_TOP:   phys_top_d   = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_end_q <= KERNEL_END_RST;
      phys_top_q   <= PHYS_TOP_RST;
    end else begin
      kernel_end_q <= kernel_end_d;
      phys_top_q   <= phys_top_d;
    end
  end

  assign cfg.kernel_end = kernel_end_q;
  assign cfg.phys_top   = phys_top_q;

  // Front: checks the address and maps it to a frame index
  rpfa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (!stat.clearing),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .page_addr_i  (page_addr_i),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  rpfa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // Back: count/stack memories, sweeps, output register
  rpfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res),
    .stat_o       (stat)
  );

  assign status_o      = res.status;
  assign result_addr_o = res.addr;
  assign copy_needed_o = res.copy_needed;
  assign page_freed_o  = res.page_freed;
  assign free_pages_o  = res.free_pages;

  // Checks
  `RPFA_ASSERT_NOW(a_clear_quiet, clk_i, rst_ni, stat.clearing, !out_valid_o && !in_ready_o, "beat moved during count clear")
  `RPFA_ASSERT_NOW(a_fail_clean, clk_i, rst_ni, out_valid_o && (status_o != STAT_OK), (result_addr_o == '0) && !copy_needed_o && !page_freed_o, "failed op carries data")
  `RPFA_ASSERT_NOW(a_copy_excl, clk_i, rst_ni, out_valid_o && copy_needed_o, !page_freed_o && (result_addr_o[PAGE_SHIFT-1:0] == '0), "bad copy result")
  `RPFA_ASSERT_NEXT(a_clear_done, clk_i, rst_ni, $fell(stat.clearing), !stat.clearing, "count clear restarted")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the page frame allocator.
//   - frame_ledger mirrors the allocator: free stack, per-frame use counts and
//     the two bound registers. Every accepted input beat is applied to it right
//     away and the result it implies is queued; every output beat is matched
//     against the head of that queue field by field.
//   - Stimulus is driven from plain tasks. Random operations draw close to
//     half their addresses from frames the ledger knows were handed out, so
//     free, addref and copy_deref often act on live pages.
module tb_top;
  import rpfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 20;

  class frame_ledger;
    logic [ADDR_W-1:0]      kernel_end = KERNEL_END_RST;
    logic [ADDR_W-1:0]      phys_top   = PHYS_TOP_RST;
    int unsigned            free_list [NUM_PAGES];
    int unsigned            free_top;
    logic [COUNT_WIDTH-1:0] use_count [NUM_PAGES];
    int unsigned            handed_out [$];
    rpfa_result_t           due_results [$];
    int unsigned            errors;

    function new();
      free_top = 0;
      errors   = 0;
      foreach (use_count[i]) use_count[i] = '0;
    endfunction

    static function logic [ADDR_W-1:0] frame_at(input int unsigned idx);
      logic [63:0] wide;
      wide = (64'(BASE_PAGE) + 64'(idx)) << PAGE_SHIFT;
      return wide[ADDR_W-1:0];
    endfunction

    function void set_reg(input cfg_reg_e sel, input logic [ADDR_W-1:0] val);
      if (sel == CFG_KERNEL_END) kernel_end = val;
      else phys_top = val;
    endfunction

    // Aligned, inside both bounds and inside the managed page window.
    function bit page_index(input logic [ADDR_W-1:0] a, output int unsigned idx);
      logic [ADDR_W-1:0] pn;
      pn  = a >> PAGE_SHIFT;
      idx = 0;
      if ((a & ((ADDR_W'(1) << PAGE_SHIFT) - 1)) != 0) return 0;
      if (a < kernel_end || a >= phys_top) return 0;
      if (pn < BASE_PAGE || pn - BASE_PAGE >= NUM_PAGES) return 0;
      idx = pn - BASE_PAGE;
      return 1;
    endfunction

    // A push onto a full stack is dropped.
    function void push_frame(input int unsigned idx);
      if (free_top < NUM_PAGES) begin
        free_list[free_top] = idx;
        free_top++;
      end
    endfunction

    function int unsigned pop_frame();
      int unsigned idx;
      free_top--;
      idx = free_list[free_top] % NUM_PAGES;
      use_count[idx] = 1;
      handed_out.push_back(idx);
      return idx;
    endfunction

    function void apply_op(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] pa);
      rpfa_result_t r;
      int unsigned  idx;
      logic [63:0]  psz, lo, fa;
      r        = '0;
      r.status = STAT_OK;
      case (fn)
        FN_ALLOC: begin
          if (free_top == 0) r.status = STAT_OOM;
          else r.addr = frame_at(pop_frame());
        end
        FN_FREE: begin
          if (!page_index(pa, idx)) begin
            r.status = STAT_BAD_ADDR;
          end else if (use_count[idx] == 0) begin
            r.status = STAT_NO_REF;
          end else begin
            use_count[idx]--;
            if (use_count[idx] == 0) begin
              push_frame(idx);
              r.page_freed = 1'b1;
            end
            r.addr = pa;
          end
        end
        FN_ADDREF: begin
          if (!page_index(pa, idx)) begin
            r.status = STAT_BAD_ADDR;
          end else if (use_count[idx] == CNT_MAX) begin
            r.status = STAT_SAT;
          end else begin
            use_count[idx]++;
            r.addr = pa;
          end
        end
        FN_COPY_DEREF: begin
          if (!page_index(pa, idx)) begin
            r.status = STAT_BAD_ADDR;
          end else if (use_count[idx] == 0) begin
            r.status = STAT_NO_REF;
          end else if (use_count[idx] == 1) begin
            r.addr = pa;
          end else if (free_top == 0) begin
            r.status = STAT_OOM;
          end else begin
            r.addr = frame_at(pop_frame());
            use_count[idx]--;
            r.copy_needed = 1'b1;
          end
        end
        FN_INIT: begin
          psz      = 64'(1) << PAGE_SHIFT;
          lo       = (64'(kernel_end) + psz - 1) & ~(psz - 1);
          free_top = 0;
          handed_out.delete();
          for (int unsigned i = 0; i < NUM_PAGES; i++) begin
            use_count[i] = '0;
            fa = 64'(frame_at(i));
            if (fa >= lo && fa + psz <= 64'(phys_top)) push_frame(i);
          end
        end
        default: ;
      endcase
      r.free_pages = FREE_W'(free_top);
      due_results.push_back(r);
    endfunction

    function void cmp(input string field, input logic [31:0] want, input logic [31:0] seen);
      if (want !== seen) begin
        errors++;
        $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
      end
    endfunction

    function void match_result(input rpfa_result_t seen);
      rpfa_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $error("result beat with no operation outstanding");
        return;
      end
      want = due_results.pop_front();
      cmp("status", 32'(want.status), 32'(seen.status));
      cmp("result_addr", want.addr, seen.addr);
      cmp("copy_needed", 32'(want.copy_needed), 32'(seen.copy_needed));
      cmp("page_freed", 32'(want.page_freed), 32'(seen.page_freed));
      cmp("free_pages", 32'(want.free_pages), 32'(seen.free_pages));
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [FUNC_W-1:0]    func_i      = '0;
  logic [ADDR_W-1:0]    page_addr_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [ADDR_W-1:0]    result_addr_o;
  logic                 copy_needed_o;
  logic                 page_freed_o;
  logic [FREE_W-1:0]    free_pages_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ADDR_W-1:0]    cfg_data_i  = '0;

  frame_ledger  ledger = new();
  rpfa_result_t seen_beat;
  bit           idle_en   = 1'b1;  // random gaps on both channels
  bit           hold_req  = 1'b0;  // asks the receiver for one long hold-off
  int unsigned  cycle_cnt = 0;

  always #4 clk_i = ~clk_i;

  refcounted_page_frame_allocator_core uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .page_addr_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .result_addr_o,
    .copy_needed_o,
    .page_freed_o,
    .free_pages_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // Watchdog: a correct run stays far below this.
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  // Result side: samples pre-edge outputs, so no race with the block's flops.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_beat.status      = status_e'(status_o);
      seen_beat.addr        = result_addr_o;
      seen_beat.copy_needed = copy_needed_o;
      seen_beat.page_freed  = page_freed_o;
      seen_beat.free_pages  = free_pages_o;
      ledger.match_result(seen_beat);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // pipeline fills and in_ready_o has to drop.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // One input beat. Valid stays high across back-to-back beats; it only drops
  // for a gap or in stop_items, never twice in one step.
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] addr);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= fn;
    page_addr_i <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ledger.apply_op(fn, addr);
  endtask

  task automatic stop_items();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (ledger.due_results.size() != 0) @(posedge clk_i);
  endtask

  // Both bound registers in one burst, valid held high between the two beats.
  task automatic set_bounds(input logic [ADDR_W-1:0] ke, input logic [ADDR_W-1:0] pt);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_KERNEL_END;
    cfg_data_i  <= ke;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ledger.set_reg(CFG_KERNEL_END, ke);
    cfg_index_i <= CFG_PHYS_TOP;
    cfg_data_i  <= pt;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ledger.set_reg(CFG_PHYS_TOP, pt);
    cfg_valid_i <= 1'b0;
  endtask

  // New bounds at a quiet point, then a full rebuild of the free stack.
  task automatic rebuild(input logic [ADDR_W-1:0] ke, input logic [ADDR_W-1:0] pt);
    stop_items();
    wait_drained();
    set_bounds(ke, pt);
    send_item(FN_INIT, $urandom());
  endtask

  // Address mix: live frames first, then frames around the managed window,
  // misaligned ones, pure noise and pages hugging either bound.
  function automatic logic [ADDR_W-1:0] pick_addr(input int lo, input int cnt);
    int r, idx;
    r   = $urandom_range(0, 99);
    idx = lo - 1 + int'($urandom_range(0, cnt + 1));
    if (idx < 0 || idx >= int'(NUM_PAGES)) idx = lo;
    if (r < 45 && ledger.handed_out.size() != 0)
      return frame_ledger::frame_at(
        ledger.handed_out[$urandom_range(0, ledger.handed_out.size() - 1)]);
    if (r < 70) return frame_ledger::frame_at(idx);
    if (r < 80) return frame_ledger::frame_at(idx) | $urandom_range(1, 4095);
    if (r < 88) return $urandom();
    if (r < 94) return (ledger.kernel_end & ~32'hFFF) - ($urandom_range(0, 1) << PAGE_SHIFT);
    return (ledger.phys_top & ~32'hFFF) + ($urandom_range(0, 1) << PAGE_SHIFT);
  endfunction

  task automatic run_random(input int n_items, input int lo, input int cnt);
    int               r;
    logic [FUNC_W-1:0] fn;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) fn = FN_ALLOC;
      else if (r < 52) fn = FN_FREE;
      else if (r < 70) fn = FN_ADDREF;
      else if (r < 92) fn = FN_COPY_DEREF;
      else fn = FUNC_W'($urandom_range(5, 7));  // unused codes
      send_item(fn, pick_addr(lo, cnt));
    end
  endtask

  initial begin
    int unsigned base, span;
    logic [ADDR_W-1:0] ke, pt;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset, before any init: empty stack, default bounds. The first
    // beat waits out the count-clearing sweep.
    send_item(FN_ALLOC, 32'hFFFF_FFFF);           // out of memory
    send_item(FN_FREE, 32'h8000_0000);            // not referenced
    send_item(FN_ADDREF, 32'h8000_0000);          // addref from zero
    send_item(FN_ADDREF, 32'h8000_0000);
    send_item(FN_COPY_DEREF, 32'h8000_0000);      // shared, nothing free
    send_item(FN_FREE, 32'h8000_0000);
    send_item(FN_COPY_DEREF, 32'h8000_0000);      // sole owner keeps the page
    send_item(FN_FREE, 32'h8000_0000);            // back on the stack
    send_item(FN_COPY_DEREF, 32'h8000_0000);      // not referenced
    send_item(FN_ALLOC, 32'h0000_0000);
    send_item(FN_ADDREF, 32'h87FF_F000);          // last managed page
    send_item(FN_FREE, 32'h8800_0000);            // at the upper bound
    send_item(FN_FREE, 32'h7FFF_F000);            // below kernel end
    send_item(FN_ADDREF, 32'h8000_0004);          // misaligned
    send_item(FN_ADDREF, 32'hFFFF_FFFF);
    send_item(FN_COPY_DEREF, 32'h0000_0000);
    send_item(3'd5, 32'hFFFF_FFFF);
    send_item(3'd6, 32'h8000_0000);
    send_item(3'd7, 32'h0000_0000);

    // Four-page pool; unaligned kernel end rounds up for init only.
    rebuild(32'h87FF_B001, 32'h8800_0000);
    repeat (5) send_item(FN_ALLOC, $urandom());   // last one runs dry
    send_item(FN_ADDREF, 32'h87FF_B000);          // under unaligned kernel end
    send_item(FN_ADDREF, 32'h87FF_F000);
    send_item(FN_COPY_DEREF, 32'h87FF_F000);      // shared, stack empty
    send_item(FN_FREE, 32'h87FF_E000);
    send_item(FN_COPY_DEREF, 32'h87FF_F000);      // new page, copy due
    send_item(FN_FREE, 32'h87FF_F000);

    // Whole window managed: full stack, so freeing a page that was free
    // already drops the push. Then share one page and split it by copy.
    rebuild(32'h0000_0000, 32'hFFFF_FFFF);
    send_item(FN_ADDREF, 32'h8000_0000);
    send_item(FN_FREE, 32'h8000_0000);
    send_item(FN_FREE, 32'h0000_1000);            // below the managed window
    send_item(FN_ALLOC, 32'h0);
    repeat (3) send_item(FN_ADDREF, 32'h8000_1000);
    send_item(FN_COPY_DEREF, 32'h8000_1000);      // new page, copy due
    send_item(FN_FREE, 32'h8000_1000);

    // Inverted bounds: nothing managed, every address rejected.
    rebuild(32'hFFFF_FFFF, 32'h0000_0000);
    send_item(FN_ALLOC, 32'h0);
    send_item(FN_ADDREF, 32'h87FF_F000);
    run_random(20, 0, 4);

    // Eight pages at the top, with one long receiver hold-off in the middle.
    rebuild(32'h87FF_8000, 32'h8800_0000);
    run_random(60, 32760, 8);
    idle_en  = 1'b0;
    hold_req = 1'b1;
    run_random(40, 32760, 8);
    idle_en  = 1'b1;
    run_random(80, 32760, 8);

    // Unaligned bounds: the page straddling phys_top is addressable but never
    // put on the stack by init.
    rebuild(32'h8000_0123, 32'h8001_0800);
    run_random(180, 0, 17);

    // Two-page pool, out of memory is common.
    rebuild(32'h8000_0000, 32'h8000_2000);
    run_random(150, 0, 2);

    // Tighter bounds without a rebuild: live pages fall outside.
    stop_items();
    wait_drained();
    set_bounds(32'h8000_1000, 32'h8000_2000);
    run_random(60, 0, 2);

    // Reset values written back explicitly.
    rebuild(KERNEL_END_RST, PHYS_TOP_RST);
    run_random(200, 0, 64);

    // Random small pool, no idling on either side to the end.
    base = $urandom_range(0, 32700);
    span = $urandom_range(1, 40);
    ke   = frame_ledger::frame_at(base) - $urandom_range(0, 4095);
    pt   = frame_ledger::frame_at(base + span) + $urandom_range(0, 4095);
    rebuild(ke, pt);
    idle_en = 1'b0;
    run_random(250, int'(base), int'(span));

    stop_items();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.due_results.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rpfa_pkg.sv
hw/rtl/rpfa_ram.sv
hw/rtl/rpfa_front.sv
hw/rtl/rpfa_queue.sv
hw/rtl/rpfa_back.sv
hw/rtl/refcounted_page_frame_allocator_core.sv
test/tb_top.sv
